// ===== sv/binary_max_heap_priority_queue_macros.svh =====
// Assertion macros for the binary max-heap priority queue.
// Used by the top level; relies on clk_i and rst_ni in the including scope.
`ifndef BINARY_MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define BINARY_MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define BMH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`endif

// ===== sv/bmhpq_pkg.sv =====
// Package for the binary max-heap priority queue: default sizes, field widths,
// command and status codes. No dependencies.
`timescale 1ns / 1ps
package bmhpq_pkg;
  localparam int unsigned DEF_HEAP_DEPTH    = 512;
  localparam int unsigned DEF_PRIORITY_BITS = 8;
  localparam int unsigned DEF_TAG_BITS      = 16;
  localparam int unsigned CMD_BITS          = 2;
  localparam int unsigned POS_BITS          = 9;
  localparam int unsigned STATUS_BITS       = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CHANGE = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_BAD_POS = 2'd3
  } status_e;
endpackage

// ===== sv/binary_max_heap_priority_queue.sv =====
// Binary max-heap priority queue: sequencer around one heap RAM.
// Depends on bmhpq_pkg, bmhpq_ram and the assertion macro header.
//
// Usage: each input request carries a command (insert, remove maximum, or
// change the entry at a heap position) with priority, tag and position.
// Every request yields exactly one result on the output channel: the removed
// entry (for remove), a status code, the entry count and the root priority
// after the command. Both channels use valid/ready handshakes.
// One request is processed at a time; in_ready_o is high only while idle.
// Insert climbs the heap one level at a time and remove descends it one level
// at a time; change writes the entry and then runs a full bottom-up rebuild.
// The pace of each step is set by the single RAM read port, whose read data
// is registered. Rejected commands skip the heap work and read the root for
// the result before presenting it.
// Reset empties the heap by clearing the fill count; the RAM is not cleared,
// since only slots below the fill count are ever used.
// When the receiver stalls, the result is held in the output registers and no
// new request is taken until it is accepted.
`timescale 1ns / 1ps
`include "binary_max_heap_priority_queue_macros.svh"
module binary_max_heap_priority_queue #(
  parameter int unsigned HEAP_DEPTH    = bmhpq_pkg::DEF_HEAP_DEPTH,
  parameter int unsigned PRIORITY_BITS = bmhpq_pkg::DEF_PRIORITY_BITS,
  parameter int unsigned TAG_BITS      = bmhpq_pkg::DEF_TAG_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [bmhpq_pkg::CMD_BITS-1:0]      cmd_i,
  input  logic [PRIORITY_BITS-1:0]            entry_priority_i,
  input  logic [TAG_BITS-1:0]                 entry_tag_i,
  input  logic [bmhpq_pkg::POS_BITS-1:0]      position_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                removed_valid_o,
  output logic [PRIORITY_BITS-1:0]            removed_priority_o,
  output logic [TAG_BITS-1:0]                 removed_tag_o,
  output logic [bmhpq_pkg::STATUS_BITS-1:0]   status_o,
  output logic [$clog2(HEAP_DEPTH+1)-1:0]     entry_count_o,
  output logic [PRIORITY_BITS-1:0]            top_priority_o
);
  import bmhpq_pkg::*;

  localparam int unsigned EW  = PRIORITY_BITS + TAG_BITS;
  localparam int unsigned AW  = $clog2(HEAP_DEPTH);
  localparam int unsigned CW  = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned NW  = AW + 2;
  localparam int unsigned CPW = (POS_BITS > CW) ? POS_BITS : CW;

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_UP_RD    = 13'b0000000000010,
    S_UP_CMP   = 13'b0000000000100,
    S_RM_ROOT  = 13'b0000000001000,
    S_RM_LAST  = 13'b0000000010000,
    S_DN_RDL   = 13'b0000000100000,
    S_DN_RDR   = 13'b0000001000000,
    S_DN_CMP   = 13'b0000010000000,
    S_HF_NEXT  = 13'b0000100000000,
    S_HF_LOAD  = 13'b0001000000000,
    S_TOP_RD   = 13'b0010000000000,
    S_TOP_WAIT = 13'b0100000000000,
    S_OUT      = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] hf_q, hf_d;
  logic [AW-1:0] k_q, k_d;
  logic [EW-1:0] cur_q, cur_d;
  logic [EW-1:0] lc_q, lc_d;
  logic          has_right_q, has_right_d;
  logic          heapify_q, heapify_d;
  logic          rm_valid_q, rm_valid_d;
  logic [EW-1:0] rm_entry_q, rm_entry_d;
  status_e       status_q, status_d;
  logic [PRIORITY_BITS-1:0] top_q, top_d;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  bmhpq_ram #(
    .WIDTH (EW),
    .DEPTH (HEAP_DEPTH)
  ) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Child and parent indexes of the current hole.
  logic [NW-1:0] left_w, right_w, fill_w;
  logic [AW-1:0] up_idx;
  logic [CW-1:0] fill_m1;
  logic [CPW-1:0] pos_c, fill_c;
  logic [PRIORITY_BITS-1:0] cur_prio, lc_prio, rd_prio, best_prio;
  logic left_win, right_win;

  assign left_w   = {1'b0, k_q, 1'b1};
  assign right_w  = left_w + NW'(1);
  assign fill_w   = NW'(fill_q);
  assign up_idx   = AW'((k_q - AW'(1)) >> 1);
  assign fill_m1  = fill_q - CW'(1);
  assign pos_c    = CPW'(position_i);
  assign fill_c   = CPW'(fill_q);
  assign cur_prio = cur_q[EW-1:TAG_BITS];
  assign lc_prio  = lc_q[EW-1:TAG_BITS];
  assign rd_prio  = rdata[EW-1:TAG_BITS];
  assign left_win  = lc_prio > cur_prio;
  assign best_prio = left_win ? lc_prio : cur_prio;
  assign right_win = has_right_q && (rd_prio > best_prio);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    hf_d        = hf_q;
    k_d         = k_q;
    cur_d       = cur_q;
    lc_d        = lc_q;
    has_right_d = has_right_q;
    heapify_d   = heapify_q;
    rm_valid_d  = rm_valid_q;
    rm_entry_d  = rm_entry_q;
    status_d    = status_q;
    top_d       = top_q;
    we    = 1'b0;
    waddr = k_q;
    wdata = cur_q;
    re    = 1'b0;
    raddr = k_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          rm_valid_d = 1'b0;
          rm_entry_d = '0;
          status_d   = ST_OK;
          heapify_d  = 1'b0;
          cur_d      = {entry_priority_i, entry_tag_i};
          state_d    = S_TOP_RD;
          case (cmd_i)
            CMD_INSERT: begin
              if (fill_q >= CW'(HEAP_DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                k_d     = fill_q[AW-1:0];
                fill_d  = fill_q + CW'(1);
                state_d = S_UP_RD;
              end
            end
            CMD_REMOVE: begin
              if (fill_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                re      = 1'b1;
                raddr   = '0;
                state_d = S_RM_ROOT;
              end
            end
            CMD_CHANGE: begin
              if (pos_c >= fill_c) begin
                status_d = ST_BAD_POS;
              end else begin
                we        = 1'b1;
                waddr     = pos_c[AW-1:0];
                wdata     = {entry_priority_i, entry_tag_i};
                hf_d      = fill_q >> 1;
                heapify_d = 1'b1;
                state_d   = S_HF_NEXT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_UP_RD: begin
        if (k_q == '0) begin
          we      = 1'b1;
          state_d = S_TOP_RD;
        end else begin
          re      = 1'b1;
          raddr   = up_idx;
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (cur_prio > rd_prio) begin
          wdata   = rdata;
          k_d     = up_idx;
          state_d = S_UP_RD;
        end else begin
          state_d = S_TOP_RD;
        end
      end
      S_RM_ROOT: begin
        rm_valid_d = 1'b1;
        rm_entry_d = rdata;
        re         = 1'b1;
        raddr      = fill_m1[AW-1:0];
        state_d    = S_RM_LAST;
      end
      S_RM_LAST: begin
        cur_d   = rdata;
        fill_d  = fill_m1;
        k_d     = '0;
        state_d = S_DN_RDL;
      end
      S_DN_RDL: begin
        if (left_w >= fill_w) begin
          we      = 1'b1;
          state_d = heapify_q ? S_HF_NEXT : S_TOP_RD;
        end else begin
          re      = 1'b1;
          raddr   = left_w[AW-1:0];
          state_d = S_DN_RDR;
        end
      end
      S_DN_RDR: begin
        lc_d        = rdata;
        has_right_d = right_w < fill_w;
        re          = right_w < fill_w;
        raddr       = right_w[AW-1:0];
        state_d     = S_DN_CMP;
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (right_win) begin
          wdata   = rdata;
          k_d     = right_w[AW-1:0];
          state_d = S_DN_RDL;
        end else if (left_win) begin
          wdata   = lc_q;
          k_d     = left_w[AW-1:0];
          state_d = S_DN_RDL;
        end else begin
          state_d = heapify_q ? S_HF_NEXT : S_TOP_RD;
        end
      end
      S_HF_NEXT: begin
        if (hf_q == '0) begin
          state_d = S_TOP_RD;
        end else begin
          hf_d    = hf_q - CW'(1);
          k_d     = hf_d[AW-1:0];
          re      = 1'b1;
          raddr   = hf_d[AW-1:0];
          state_d = S_HF_LOAD;
        end
      end
      S_HF_LOAD: begin
        cur_d   = rdata;
        state_d = S_DN_RDL;
      end
      S_TOP_RD: begin
        re      = 1'b1;
        raddr   = '0;
        state_d = S_TOP_WAIT;
      end
      S_TOP_WAIT: begin
        top_d   = (fill_q != '0) ? rd_prio : '0;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hf_q        <= hf_d;
    k_q         <= k_d;
    cur_q       <= cur_d;
    lc_q        <= lc_d;
    has_right_q <= has_right_d;
    heapify_q   <= heapify_d;
    rm_valid_q  <= rm_valid_d;
    rm_entry_q  <= rm_entry_d;
    status_q    <= status_d;
    top_q       <= top_d;
  end

  assign in_ready_o         = (state_q == S_IDLE);
  assign out_valid_o        = (state_q == S_OUT);
  assign removed_valid_o    = rm_valid_q;
  assign removed_priority_o = rm_entry_q[EW-1:TAG_BITS];
  assign removed_tag_o      = rm_entry_q[TAG_BITS-1:0];
  assign status_o           = status_q;
  assign entry_count_o      = fill_q;
  assign top_priority_o     = top_q;

  `BMH_ASSERT(a_fill_bound, fill_q <= CW'(HEAP_DEPTH), "fill count beyond heap depth")
  `BMH_ASSERT(a_one_side, !(in_ready_o && out_valid_o), "ready and result valid together")
  `BMH_ASSERT(a_back_idle, (out_valid_o && out_ready_i) |=> in_ready_o, "no return to idle")
  `BMH_ASSERT(a_rm_ok, (out_valid_o && removed_valid_o) |-> (status_o == ST_OK), "removed with error")
endmodule

// ===== sv/bmhpq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module bmhpq_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the binary max-heap priority queue: a directed table,
// then random insert/remove/change traffic checked against a heap predictor.
// Depends on bmhpq_pkg and the binary_max_heap_priority_queue top level.
`timescale 1ns / 1ps
module tb;
  import bmhpq_pkg::*;

  localparam int DEPTH = 512;

  typedef struct packed {
    logic       rv;
    logic [7:0] rp;
    logic [15:0] rt;
    logic [1:0] st;
    logic [9:0] cnt;
    logic [7:0] top;
  } result_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [7:0]  prio;
    logic [15:0] tag;
    logic [8:0]  pos;
    bit          typed;
    result_t     res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] cmd_i = '0;
  logic [7:0] entry_priority_i = '0;
  logic [15:0] entry_tag_i = '0;
  logic [8:0] position_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic removed_valid_o;
  logic [7:0] removed_priority_o;
  logic [15:0] removed_tag_o;
  logic [1:0] status_o;
  logic [9:0] entry_count_o;
  logic [7:0] top_priority_o;

  binary_max_heap_priority_queue u_dut (.*);

  always #10 clk_i = ~clk_i;

  // Model heap: priority and tag per slot, plus the fill count.
  logic [7:0]  heap_prio [DEPTH];
  logic [15:0] heap_tag [DEPTH];
  int unsigned fill;
  result_t expected_q[$];
  int errors = 0;
  int n_results = 0;
  bit no_idle = 1'b0;

  task automatic report(input string what, input int got, input int want);
    $display("Mismatch on result %0d: %s got %0d expected %0d", n_results, what, got, want);
    errors++;
  endtask

  function automatic void swap_slots(int a, int b);
    logic [7:0] p;
    logic [15:0] t;
    p = heap_prio[a]; heap_prio[a] = heap_prio[b]; heap_prio[b] = p;
    t = heap_tag[a];  heap_tag[a]  = heap_tag[b];  heap_tag[b]  = t;
  endfunction

  function automatic void sink(int k);
    int best, c;
    while (k < fill) begin
      best = k;
      for (int j = 1; j <= 2; j++) begin
        c = 2 * k + j;
        if (c < fill && heap_prio[c] > heap_prio[best]) best = c;
      end
      if (best == k) return;
      swap_slots(k, best);
      k = best;
    end
  endfunction

  // Apply one request to the model heap and return the result it should give.
  function automatic result_t heap_apply(logic [1:0] cmd, logic [7:0] p, logic [15:0] t,
                                         logic [8:0] pos);
    result_t r;
    int k;
    r = '0;
    if (cmd == CMD_INSERT) begin
      if (fill >= DEPTH) r.st = ST_FULL;
      else begin
        heap_prio[fill] = p; heap_tag[fill] = t;
        k = fill; fill++;
        while (k > 0 && heap_prio[k] > heap_prio[(k - 1) / 2]) begin
          swap_slots(k, (k - 1) / 2);
          k = (k - 1) / 2;
        end
      end
    end else if (cmd == CMD_REMOVE) begin
      if (fill == 0) r.st = ST_EMPTY;
      else begin
        r.rv = 1'b1; r.rp = heap_prio[0]; r.rt = heap_tag[0];
        swap_slots(0, fill - 1);
        fill--;
        sink(0);
      end
    end else if (cmd == CMD_CHANGE) begin
      if (pos >= fill) r.st = ST_BAD_POS;
      else begin
        heap_prio[pos] = p; heap_tag[pos] = t;
        for (k = fill / 2 - 1; k >= 0; k--) sink(k);
      end
    end
    r.cnt = 10'(fill);
    r.top = (fill > 0) ? heap_prio[0] : 8'd0;
    return r;
  endfunction

  // Each request starts at a falling edge; valid stays high between requests
  // unless an idle burst drops it.
  task automatic send(input logic [1:0] cmd, input logic [7:0] p, input logic [15:0] t,
                      input logic [8:0] pos, input bit typed, input result_t want);
    result_t r;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    cmd_i <= cmd; entry_priority_i <= p; entry_tag_i <= t; position_i <= pos;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    r = heap_apply(cmd, p, t, pos);
    if (typed && r != want) begin
      $display("Directed row disagrees with predictor");
      errors++;
    end
    expected_q.push_back(r);
    @(negedge clk_i);
  endtask

  // Receiver: random stall bursts, compare each result with the oldest expectation.
  initial begin
    result_t w;
    int stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) stall--;
      else if (!no_idle && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 5);
      out_ready_i <= (stall == 0);
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("Result with nothing expected");
          errors++;
        end else begin
          w = expected_q.pop_front();
          if (removed_valid_o !== w.rv) report("removed_valid", removed_valid_o, w.rv);
          if (removed_priority_o !== w.rp) report("removed_priority", removed_priority_o, w.rp);
          if (removed_tag_o !== w.rt) report("removed_tag", removed_tag_o, w.rt);
          if (status_o !== w.st) report("status", status_o, w.st);
          if (entry_count_o !== w.cnt) report("entry_count", entry_count_o, w.cnt);
          if (top_priority_o !== w.top) report("top_priority", top_priority_o, w.top);
        end
        n_results++;
      end
    end
  end

  initial begin
    #100ms;
    $display("Timeout");
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    row_t rows[$];
    row_t rw;
    int kind, limit;
    fill = 0;
    // Directed table: typed results are the obvious ones (empty, extremes, errors).
    rows = '{
      '{CMD_REMOVE, 8'd0, 16'd0, 9'd0, 1, '{1'b0, 8'd0, 16'd0, ST_EMPTY, 10'd0, 8'd0}},
      '{CMD_CHANGE, 8'd5, 16'd5, 9'd0, 1, '{1'b0, 8'd0, 16'd0, ST_BAD_POS, 10'd0, 8'd0}},
      '{2'd3, 8'hFF, 16'hFFFF, 9'h1FF, 1, '{1'b0, 8'd0, 16'd0, ST_OK, 10'd0, 8'd0}},
      '{CMD_INSERT, 8'hFF, 16'hFFFF, 9'h1FF, 1, '{1'b0, 8'd0, 16'd0, ST_OK, 10'd1, 8'hFF}},
      '{CMD_REMOVE, 8'd0, 16'd0, 9'd0, 1, '{1'b1, 8'hFF, 16'hFFFF, ST_OK, 10'd0, 8'd0}},
      '{CMD_INSERT, 8'd0, 16'd0, 9'd0, 1, '{1'b0, 8'd0, 16'd0, ST_OK, 10'd1, 8'd0}},
      '{CMD_INSERT, 8'd7, 16'h1111, 9'd0, 0, '0},
      '{CMD_INSERT, 8'd7, 16'h2222, 9'd0, 0, '0},
      '{CMD_INSERT, 8'd9, 16'h3333, 9'd0, 0, '0},
      '{CMD_INSERT, 8'd7, 16'h4444, 9'd0, 0, '0},
      '{CMD_CHANGE, 8'd200, 16'hAAAA, 9'd4, 0, '0},
      '{CMD_CHANGE, 8'd1, 16'h5555, 9'd0, 0, '0},
      '{CMD_CHANGE, 8'd3, 16'h0, 9'd5, 1, '{1'b0, 8'd0, 16'd0, ST_BAD_POS, 10'd5, 8'd9}},
      '{CMD_REMOVE, 8'd0, 16'd0, 9'd0, 0, '0},
      '{CMD_REMOVE, 8'd0, 16'd0, 9'd0, 0, '0},
      '{CMD_REMOVE, 8'd0, 16'd0, 9'd0, 0, '0},
      '{CMD_REMOVE, 8'd0, 16'd0, 9'd0, 0, '0},
      '{CMD_REMOVE, 8'd0, 16'd0, 9'd0, 0, '0},
      '{CMD_REMOVE, 8'd0, 16'd0, 9'd0, 1, '{1'b0, 8'd0, 16'd0, ST_EMPTY, 10'd0, 8'd0}}
    };
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (rows[i]) begin
      rw = rows[i];
      send(rw.cmd, rw.prio, rw.tag, rw.pos, rw.typed, rw.res);
    end
    // Pause until every directed result has come back.
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);

    // Fill the heap to the top, then push against the full heap.
    for (int i = 0; i < DEPTH + 3; i++)
      send(i < DEPTH ? CMD_INSERT : 2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom),
           9'($urandom), 0, '0);
    for (int i = 0; i < 6; i++)
      send(CMD_CHANGE, 8'($urandom), 16'($urandom), 9'($urandom), 0, '0);
    // Drain it empty.
    for (int i = 0; i < DEPTH + 2; i++)
      send(CMD_REMOVE, 8'($urandom), 16'($urandom), 9'($urandom), 0, '0);

    // Random mix, weighted so the heap size wanders; ties come from narrow priorities.
    for (int i = 0; i < 900; i++) begin
      if (i == 800) no_idle = 1'b1;
      kind = $urandom_range(0, 19);
      limit = (fill > 0) ? fill - 1 : 0;
      if (kind < 9)
        send(CMD_INSERT, (i % 3 == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom),
             16'($urandom), 9'($urandom), 0, '0);
      else if (kind < 16)
        send(CMD_REMOVE, 8'($urandom), 16'($urandom), 9'($urandom), 0, '0);
      else if (kind < 19)
        send(CMD_CHANGE, 8'($urandom), 16'($urandom),
             (kind == 18) ? 9'($urandom) : 9'($urandom_range(0, limit)), 0, '0);
      else send(2'd3, 8'($urandom), 16'($urandom), 9'($urandom), 0, '0);
    end
    in_valid_i <= 1'b0;

    fork
      while (expected_q.size() != 0) @(negedge clk_i);
      begin
        repeat (200000) @(negedge clk_i);
      end
    join_any
    repeat (50) @(negedge clk_i);
    $display("Covered %0d results: fill to full, drain to empty, error codes,", n_results);
    $display("and a random insert/remove/change mix with ties.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
